// ===== src/hcf_pkg.sv =====
// hcf_pkg: shared constants, state encoding and sizing helpers for the
// heading complementary filter; no dependencies
`timescale 1ns / 1ps

package hcf_pkg;

  // default angle precision: heading lsb is 2^-6 degree
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 6;

  // fixed field widths
  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned STEP_W    = 15;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned HDG_OUT_W = 15;

  // rate * step_time carries 20 fraction bits, the blend term 16
  localparam int unsigned PROD_FRAC = 20;
  localparam int unsigned CORR_SH   = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd62259;
  localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [STEP_W-1:0]  STEP_RST  = 15'd1311;

  // register word index (byte address bit 2)
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_STEP  = 1'b1;

  // input item kind carried in tuser
  localparam logic OP_SEED   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_TURN = 7'b0000010,
    ST_RED_GYRO = 7'b0000100,
    ST_RED_DIFF = 7'b0001000,
    ST_MUL_CORR = 7'b0010000,
    ST_RED_HDG  = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  function automatic longint full_turn(input int unsigned afb);
    full_turn = longint'(360) << afb;
  endfunction

  // largest value ever handed to the modular reducer
  function automatic longint red_bound(input int unsigned afb);
    red_bound = longint'(32768) + 7 * full_turn(afb);
  endfunction

  // top shift k so that full << (k+1) exceeds the reducer bound
  function automatic int red_top(input int unsigned afb);
    int k;
    k = 0;
    for (int i = 0; i < 32; i++) begin
      if ((full_turn(afb) << (k + 1)) <= red_bound(afb)) begin
        k = k + 1;
      end
    end
    red_top = k;
  endfunction

endpackage

// ===== src/heading_complementary_filter.sv =====
// heading_complementary_filter: gyro / magnetometer heading fusion with a
// bit-serial multiplier and a restoring modular reducer; uses hcf_pkg
// Usage
//   s_axis: one transaction per item; tuser[0] is op (0 seed, 1 update),
//   tdata[15:0] gyro_rate (signed Q12.4 dps), tdata[30:16] mag_heading.
//   m_axis: one transaction per item, tdata[14:0] the new fused heading.
//   apb: alpha at byte address 0, step_time at 4; write only while idle.
// Sequence (K = red_top, 3 at the default precision)
//   a seed makes one pass of the compare-subtract reducer, from full << K
//   down to the full turn; an update makes two passes of the
//   1-bit-per-cycle shift-add multiplier (17 multiplier bits) and three
//   passes of the compare-subtract reducer, one shifted multiple of the
//   full turn per cycle.
//   one item is in work at a time; s_axis_tready is high only while idle.
// Reset
//   heading clears to zero, alpha and step_time return to 62259 and 1311.
// Stall
//   a result waits in the output register; the next item is taken meanwhile,
//   and its result waits in the datapath until the register frees up.
`timescale 1ns / 1ps

module heading_complementary_filter
  import hcf_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // gyro_rate[15:0], mag_heading[30:16], pad[31]
  input  logic [0:0]  s_axis_tuser,   // op[0]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // heading[14:0], pad[15]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam longint FULL    = full_turn(ANGLE_FRAC_BITS);
  localparam longint HALF    = FULL / 2;
  localparam int     HW      = $clog2(FULL);
  localparam int     RW      = $clog2(red_bound(ANGLE_FRAC_BITS)) + 1;
  localparam int     KM      = red_top(ANGLE_FRAC_BITS);
  localparam int     MCW     = (HW + 1 > RATE_W) ? HW + 1 : RATE_W;
  localparam int     PRW     = MCW + 1 + ALPHA_W;
  localparam int     TURN_SH = PROD_FRAC - ANGLE_FRAC_BITS;
  localparam int     CW      = $clog2(ALPHA_W + 1);

  typedef logic signed [RW:0]    red_s_t;
  typedef logic signed [MCW-1:0] mc_t;

  localparam logic [RW-1:0]  FULL_R   = RW'(FULL);
  localparam logic [RW-1:0]  HALF_R   = RW'(HALF);
  localparam logic [RW-1:0]  DV_INIT  = RW'(FULL << KM);
  localparam red_s_t         FULL_S   = (RW + 1)'(FULL);
  localparam red_s_t         FULL3_S  = (RW + 1)'(3 * FULL);
  localparam logic [CW-1:0]  MUL_LAST = CW'(ALPHA_W);

  state_e              state_q, state_d;
  logic [ALPHA_W-1:0]  alpha_q, alpha_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [HW-1:0]       fused_q, fused_d;
  logic [HW-1:0]       gh_q, gh_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic                raw_pos_q, raw_pos_d;
  // serial multiplier
  mc_t                 mc_q, mc_d;
  logic [ALPHA_W-1:0]  mr_q, mr_d;
  logic signed [MCW:0] acc_q, acc_d;
  logic [ALPHA_W-1:0]  lo_q, lo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  // modular reducer
  logic [RW-1:0]       r_q, r_d;
  logic [RW-1:0]       dv_q, dv_d;
  // output register
  logic                ovld_q, ovld_d;
  logic [HDG_OUT_W-1:0] ohdg_q, ohdg_d;

  logic                cfg_wr;
  logic [MCW:0]        mc_ext;
  logic signed [MCW:0] mul_sum;
  logic signed [PRW-1:0] prod_s;
  logic signed [PRW-1:0] turn_full;
  logic signed [PRW-1:0] corr_full;
  red_s_t              gyro_sum;
  red_s_t              hdg_sum;
  mc_t                 diff_s;
  logic [ALPHA_W-1:0]  w_gain;
  logic                red_done;
  logic                out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_ALPHA: prdata = 32'(alpha_q);
      REG_STEP:  prdata = 32'(step_q);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    alpha_d = alpha_q;
    step_d  = step_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_ALPHA: alpha_d = pwdata[ALPHA_W-1:0];
        REG_STEP:  step_d  = pwdata[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  // shift-add step: one multiplier bit per cycle, low product bits shift out
  assign mc_ext  = {mc_q[MCW-1], mc_q};
  assign mul_sum = acc_q + (mr_q[0] ? signed'(mc_ext) : '0);
  assign prod_s  = signed'({acc_q, lo_q});

  assign turn_full = prod_s >>> TURN_SH;
  assign corr_full = prod_s >>> CORR_SH;

  // 3 full turns keep the sum positive for any gyro step
  assign gyro_sum = signed'({1'b0, RW'(fused_q)}) + FULL3_S - red_s_t'(turn_full);
  assign hdg_sum  = signed'({1'b0, RW'(gh_q)}) + FULL_S + red_s_t'(corr_full);

  // shortest difference; an exact half turn keeps the sign of the raw value
  always_comb begin
    diff_s = mc_t'(r_q) - mc_t'(HALF_R);
    if (r_q == '0 && raw_pos_q) begin
      diff_s = mc_t'(HALF_R);
    end
  end

  assign w_gain   = (alpha_q > ONE_Q16) ? '0 : ONE_Q16 - alpha_q;
  assign red_done = (dv_q == HALF_R);
  assign out_free = ~ovld_q | m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    fused_d   = fused_q;
    gh_d      = gh_q;
    mag_d     = mag_q;
    raw_pos_d = raw_pos_q;
    mc_d      = mc_q;
    mr_d      = mr_q;
    acc_d     = acc_q;
    lo_d      = lo_q;
    cnt_d     = cnt_q;
    r_d       = r_q;
    dv_d      = dv_q;
    ovld_d    = ovld_q & ~m_axis_tready;
    ohdg_d    = ohdg_q;

    // reducer and multiplier step in every busy cycle; loads below override
    if (r_q >= dv_q) begin
      r_d = r_q - dv_q;
    end
    dv_d  = dv_q >> 1;
    acc_d = mul_sum >>> 1;
    lo_d  = {mul_sum[0], lo_q[ALPHA_W-1:1]};
    mr_d  = mr_q >> 1;
    cnt_d = cnt_q + 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mag_d = s_axis_tdata[16 +: MAG_W];
          if (s_axis_tuser[0] == OP_SEED) begin
            r_d     = RW'(s_axis_tdata[16 +: MAG_W]);
            dv_d    = DV_INIT;
            state_d = ST_RED_HDG;
          end else begin
            mc_d    = mc_t'(signed'(s_axis_tdata[RATE_W-1:0]));
            mr_d    = ALPHA_W'(step_q);
            acc_d   = '0;
            lo_d    = '0;
            cnt_d   = '0;
            state_d = ST_MUL_TURN;
          end
        end
      end
      ST_MUL_TURN: begin
        if (cnt_q == MUL_LAST) begin
          r_d     = gyro_sum[RW-1:0];
          dv_d    = DV_INIT;
          state_d = ST_RED_GYRO;
        end
      end
      ST_RED_GYRO: begin
        if (red_done) begin
          gh_d      = r_q[HW-1:0];
          raw_pos_d = (RW'(mag_q) > r_q);
          r_d       = RW'(mag_q) + HALF_R + FULL_R - r_q;
          dv_d      = DV_INIT;
          state_d   = ST_RED_DIFF;
        end
      end
      ST_RED_DIFF: begin
        if (red_done) begin
          mc_d    = diff_s;
          mr_d    = w_gain;
          acc_d   = '0;
          lo_d    = '0;
          cnt_d   = '0;
          state_d = ST_MUL_CORR;
        end
      end
      ST_MUL_CORR: begin
        if (cnt_q == MUL_LAST) begin
          r_d     = hdg_sum[RW-1:0];
          dv_d    = DV_INIT;
          state_d = ST_RED_HDG;
        end
      end
      ST_RED_HDG: begin
        if (red_done) begin
          fused_d = r_q[HW-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ohdg_d  = HDG_OUT_W'(fused_q);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      alpha_q <= ALPHA_RST;
      step_q  <= STEP_RST;
      fused_q <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      alpha_q <= alpha_d;
      step_q  <= step_d;
      fused_q <= fused_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gh_q      <= gh_d;
    mag_q     <= mag_d;
    raw_pos_q <= raw_pos_d;
    mc_q      <= mc_d;
    mr_q      <= mr_d;
    acc_q     <= acc_d;
    lo_q      <= lo_d;
    cnt_q     <= cnt_d;
    r_q       <= r_d;
    dv_q      <= dv_d;
    ohdg_q    <= ohdg_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = 16'(ohdg_q);

endmodule

// ===== src/hcf_checker.sv =====
// hcf_checker: port-level assertions for heading_complementary_filter,
// attached by bind; uses hcf_pkg
`timescale 1ns / 1ps

module hcf_checker
  import hcf_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  localparam longint FULL = full_turn(ANGLE_FRAC_BITS);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // heading stays on the circle
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (longint'(m_axis_tdata[14:0]) < FULL))
    else $error("heading out of range");

endmodule

bind heading_complementary_filter hcf_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_hcf_checker (.*);
